// ===== rtl/core/blrle_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blrle_pkg
// Types, constants and helper functions shared by the binary line
// run-length encoder.
// ============================================================================
package blrle_pkg;

    localparam int CFG_W      = 13;
    localparam int CFG_MAX    = 2**CFG_W - 1;
    localparam int PIXEL_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int INDEX_W    = 2;
    localparam int MAX_RES    = 4;
    localparam int RES_IDX_W  = 2;
    localparam int RES_CNT_W  = 3;
    localparam int ACC_W      = 40;
    localparam int ACC_CNT_W  = 6;
    localparam int CODE_LEN_W = 4;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    typedef enum logic [INDEX_W-1:0] {
        REG_LINE_WIDTH       = 2'd0,
        REG_LINE_COUNT       = 2'd1,
        REG_FIRST_COLOR_MODE = 2'd2
    } reg_index_t;

    localparam logic [MODE_W-1:0] MODE_COLOR_BIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORCE_BLACK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORCE_WHITE = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0]  line_width;
        logic [CFG_W-1:0]  line_count;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
        logic [RES_CNT_W-1:0]           count;
        logic                           frame_end;
    } rec_t;

    // max(1, bit length of (tail - 1))
    function automatic logic [CODE_LEN_W-1:0] code_width(input logic [CFG_W-1:0] tail);
        logic [CFG_W-1:0]      t;
        logic [CODE_LEN_W-1:0] w;
        t = (tail == '0) ? '0 : tail - 1'b1;
        w = CODE_LEN_W'(1);
        for (int i = 1; i < CFG_W; i++)
        begin
            if (t[i])
            begin
                w = CODE_LEN_W'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/blrle_ifs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blrle channel interfaces
// Pixel input channel and code byte output channel, valid/ready handshake.
// ============================================================================
interface blrle_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [blrle_pkg::PIXEL_W-1:0]  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface blrle_code_if;
    logic                           valid;
    logic                           ready;
    logic [blrle_pkg::BYTE_W-1:0]   code_byte;
    logic                           frame_end;
    logic                           last;

    modport source (output valid, output code_byte, output frame_end, output last, input ready);
    modport sink   (input valid, input code_byte, input frame_end, input last, output ready);
endinterface

// ===== rtl/core/blrle_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blrle_core
// Input register, run tracking and single-pass bit packing of one pixel into
// a record of up to four code bytes.
// ============================================================================
module blrle_core #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_LINES = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  blrle_pkg::cfg_t cfg,
    input  logic            restart,
    blrle_pixel_if.sink     pixels,
    output blrle_pkg::rec_t rec,
    output logic            push,
    input  logic            can_push
);
    import blrle_pkg::*;

    localparam int EFF_W = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int EFF_L = (MAX_LINES < CFG_MAX) ? MAX_LINES : CFG_MAX;
    localparam int LW_W  = $clog2(EFF_W + 1);
    localparam int LC_W  = $clog2(EFF_L + 1);

    logic                   vld_reg;
    logic [PIXEL_W-1:0]     pix_reg;
    logic                   color_reg, color_next;
    logic [LW_W-1:0]        rl_reg, rl_next;
    logic [LW_W-1:0]        rem_reg, rem_next;
    logic [LW_W-1:0]        col_reg, col_next;
    logic [LC_W-1:0]        row_reg, row_next;
    logic [BYTE_W-1:0]      pend_reg, pend_next;
    logic [2:0]             pcnt_reg, pcnt_next;

    logic                   b;
    logic [LW_W-1:0]        width;
    logic [LC_W-1:0]        count;
    logic [CODE_LEN_W-1:0]  w1, w2;
    logic [ACC_W-1:0]       acc, aligned;
    logic [ACC_CNT_W-1:0]   n, sh;
    logic                   eol, fend, pad, fire;
    logic [LC_W:0]          row_inc;
    logic [RES_CNT_W-1:0]   full, nb_full;
    logic [2:0]             tail_bits;

    always_comb
    begin
        b          = |pix_reg;
        width      = cfg.line_width[LW_W-1:0];
        count      = cfg.line_count[LC_W-1:0];
        color_next = color_reg;
        rl_next    = rl_reg;
        rem_next   = rem_reg;
        col_next   = col_reg + 1'b1;
        row_next   = row_reg;
        acc        = ACC_W'(pend_reg);
        n          = ACC_CNT_W'(pcnt_reg);
        w1         = '0;
        w2         = '0;
        fend       = 1'b0;

        if (col_reg == '0)
        begin
            case (cfg.mode)
                MODE_COLOR_BIT:
                begin
                    acc        = {acc[ACC_W-2:0], b};
                    n          = n + 1'b1;
                    color_next = b;
                end
                MODE_FORCE_BLACK: color_next = 1'b0;
                default:          color_next = 1'b1;
            endcase
            rl_next  = LW_W'(1);
            rem_next = width;
        end
        else if (b == color_reg)
        begin
            rl_next = rl_reg + 1'b1;
        end
        else
        begin
            w1         = code_width(CFG_W'(rem_reg));
            acc        = (acc << w1) | ACC_W'(rl_reg - 1'b1);
            n          = n + ACC_CNT_W'(w1);
            rem_next   = rem_reg - rl_reg;
            color_next = ~color_reg;
            rl_next    = LW_W'(1);
        end

        eol     = ({1'b0, col_reg} + 1'b1) >= {1'b0, width};
        row_inc = {1'b0, row_reg} + 1'b1;
        if (eol)
        begin
            w2       = code_width(CFG_W'(rem_next));
            acc      = (acc << w2) | ACC_W'(rl_next - 1'b1);
            n        = n + ACC_CNT_W'(w2);
            col_next = '0;
            if (row_inc >= {1'b0, count})
            begin
                fend     = 1'b1;
                row_next = '0;
            end
            else
            begin
                row_next = row_inc[LC_W-1:0];
            end
        end

        sh        = ACC_CNT_W'(ACC_W) - n;
        aligned   = acc << sh;
        full      = n[ACC_CNT_W-1:3];
        tail_bits = n[2:0];
        nb_full   = (full > RES_CNT_W'(MAX_RES)) ? RES_CNT_W'(MAX_RES) : full;
        pad       = fend && (tail_bits != '0) && (nb_full < RES_CNT_W'(MAX_RES));

        for (int k = 0; k < MAX_RES; k++)
        begin
            rec.bytes[k] = aligned[ACC_W-1-BYTE_W*k -: BYTE_W];
        end
        rec.count     = nb_full + RES_CNT_W'(pad);
        rec.frame_end = fend && (pad || (tail_bits == '0));

        pend_next = fend ? '0 : (acc[BYTE_W-1:0] & ~(8'hFF << tail_bits));
        pcnt_next = fend ? '0 : tail_bits;

        fire         = vld_reg && ((rec.count == '0) || can_push);
        push         = fire && (rec.count != '0);
        pixels.ready = !vld_reg || fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            color_reg <= 1'b0;
            rl_reg    <= '0;
            rem_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            pcnt_reg  <= '0;
        end
        else if (restart)
        begin
            color_reg <= 1'b0;
            rl_reg    <= '0;
            rem_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            pcnt_reg  <= '0;
        end
        else
        begin
            if (pixels.ready)
            begin
                vld_reg <= pixels.valid;
            end
            if (fire)
            begin
                color_reg <= color_next;
                rl_reg    <= rl_next;
                rem_reg   <= rem_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                pend_reg  <= pend_next;
                pcnt_reg  <= pcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixels.valid && pixels.ready)
        begin
            pix_reg <= pixels.pixel;
        end
    end

endmodule

// ===== rtl/core/blrle_outq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blrle_outq
// Queue of per-pixel byte records; hands the bytes of each record out one
// item at a time.
// ============================================================================
module blrle_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  blrle_pkg::rec_t rec,
    input  logic            push,
    output logic            can_push,
    blrle_code_if.source    codes
);
    import blrle_pkg::*;

    rec_t                  recs_reg [QDEPTH];
    logic [QPTR_W-1:0]     head_reg, tail_reg;
    logic [QPTR_W:0]       cnt_reg;
    logic [RES_IDX_W-1:0]  sub_reg;
    rec_t                  cur;
    logic                  last_byte, pop, take;

    always_comb
    begin
        cur             = recs_reg[head_reg];
        last_byte       = ({1'b0, sub_reg} + 1'b1) == cur.count;
        codes.valid     = cnt_reg != '0;
        codes.code_byte = cur.bytes[sub_reg];
        codes.last      = last_byte;
        codes.frame_end = last_byte && cur.frame_end;
        take            = codes.valid && codes.ready;
        pop             = take && last_byte;
        can_push        = cnt_reg != (QPTR_W + 1)'(QDEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
            sub_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
                sub_reg  <= '0;
            end
            else if (take)
            begin
                sub_reg <= sub_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            recs_reg[tail_reg] <= rec;
        end
    end

endmodule

// ===== rtl/core/binary_line_run_length_encoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// binary_line_run_length_encoder
// Run-length coder for binary images, line by line, packed MSB first.
// ============================================================================
// Takes one pixel per cycle; a pixel is registered, coded from the register
// and its 0 to 4 code bytes are queued as one record (4 records deep). Bytes
// leave one per cycle while the receiver is ready, so one pixel per cycle
// holds while the pixels produce on average no more than one byte each;
// longer bursts of short runs back-pressure the input once the record queue
// fills. A write to index 0 to 2 restarts the frame and drops a partial byte.
module binary_line_run_length_encoder #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_LINES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          write_en,
    input  logic [blrle_pkg::INDEX_W-1:0] write_index,
    input  logic [blrle_pkg::CFG_W-1:0]   write_data,
    blrle_pixel_if.sink                   pixels,
    blrle_code_if.source                  codes
);
    import blrle_pkg::*;

    localparam int EFF_W = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int EFF_L = (MAX_LINES < CFG_MAX) ? MAX_LINES : CFG_MAX;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  count_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              restart;
    cfg_t              cfg;
    rec_t              rec;
    logic              push, can_push;

    function automatic logic [CFG_W-1:0] clamp_len(input logic [CFG_W-1:0] v, input int hi);
        logic [CFG_W-1:0] x;
        x = (v == '0) ? CFG_W'(1) : v;
        if (int'(x) > hi)
        begin
            x = CFG_W'(hi);
        end
        return x;
    endfunction

    always_comb
    begin
        restart = write_en && ((write_index == REG_LINE_WIDTH) ||
                               (write_index == REG_LINE_COUNT) ||
                               (write_index == REG_FIRST_COLOR_MODE));
        cfg.line_width = width_reg;
        cfg.line_count = count_reg;
        cfg.mode       = mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CFG_W'(1);
            count_reg <= CFG_W'(1);
            mode_reg  <= MODE_COLOR_BIT;
        end
        else if (write_en)
        begin
            unique case (write_index)
                REG_LINE_WIDTH:       width_reg <= clamp_len(write_data, EFF_W);
                REG_LINE_COUNT:       count_reg <= clamp_len(write_data, EFF_L);
                REG_FIRST_COLOR_MODE: mode_reg  <= write_data[MODE_W-1:0];
                default:              ;
            endcase
        end
    end

    blrle_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINES (MAX_LINES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .restart  (restart),
        .pixels   (pixels),
        .rec      (rec),
        .push     (push),
        .can_push (can_push)
    );

    blrle_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .rec      (rec),
        .push     (push),
        .can_push (can_push),
        .codes    (codes)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives binary_line_run_length_encoder with binary images through the
// pixel channel. A run-length coder inside the bench predicts every code byte
// and its flags, and each byte leaving the block is checked against it.
// Directed register limits, color modes and frame endings come first. Random
// images follow under four mixes of sender gaps and receiver stalls.
// ============================================================================
module testbench;
    import blrle_pkg::*;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_LINES    = 4096;
    localparam int SETTLE       = 16;
    localparam int STALL_LIMIT  = 1000;
    localparam int RESET_CYCLES = 7;
    localparam int WIDE_LINE_PX = 48;
    localparam int PHASE_SLACK  = 16;
    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0]  MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              frame_end;
        logic              last;
    } code_item_t;

    logic               clk;
    logic               rst_n;
    logic               write_en;
    logic [INDEX_W-1:0] write_index;
    logic [CFG_W-1:0]   write_data;

    blrle_pixel_if pixel_ch();
    blrle_code_if  code_ch();

    binary_line_run_length_encoder #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_LINES(MAX_LINES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .write_en(write_en),
        .write_index(write_index),
        .write_data(write_data),
        .pixels(pixel_ch),
        .codes(code_ch)
    );

    // coder state
    int unsigned       line_w = 1;
    int unsigned       line_n = 1;
    logic [MODE_W-1:0] color_mode = MODE_COLOR_BIT;
    logic              run_bit = 1'b0;
    int unsigned       run_len = 0;
    int unsigned       tail_px = 1;
    int unsigned       col = 0;
    int unsigned       row = 0;
    logic [BYTE_W-1:0] bit_acc = '0;
    int unsigned       bit_cnt = 0;

    code_item_t  pixel_codes[$];
    code_item_t  expected_codes[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned pixels_sent = 0;
    int unsigned codes_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned code_len(int unsigned tail);
        int unsigned t;
        int unsigned w;
        t = (tail > 0) ? tail - 1 : 0;
        w = 1;
        while (w < 31 && (t >> w) != 0)
        begin
            w++;
        end
        return w;
    endfunction

    function automatic int unsigned clamp_cfg(logic [CFG_W-1:0] v, int unsigned hi);
        int unsigned x;
        x = v;
        if (x == 0)
        begin
            x = 1;
        end
        if (x > hi)
        begin
            x = hi;
        end
        return x;
    endfunction

    function void emit_byte(logic [BYTE_W-1:0] v, logic fe);
        if (pixel_codes.size() < MAX_RES)
        begin
            pixel_codes.push_back('{v, fe, 1'b0});
        end
    endfunction

    function void pack_bit(logic b);
        bit_acc = {bit_acc[BYTE_W-2:0], b};
        bit_cnt++;
        if (bit_cnt >= BYTE_W)
        begin
            emit_byte(bit_acc, 1'b0);
            bit_acc = '0;
            bit_cnt = 0;
        end
    endfunction

    function automatic void pack_code(int unsigned value, int unsigned len);
        for (int i = int'(len) - 1; i >= 0; i--)
        begin
            pack_bit(value[i]);
        end
    endfunction

    function void restart_frame();
        run_bit = 1'b0;
        run_len = 0;
        tail_px = line_w;
        col = 0;
        row = 0;
        bit_acc = '0;
        bit_cnt = 0;
    endfunction

    function void apply_write(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_LINE_WIDTH:       line_w = clamp_cfg(data, MAX_WIDTH);
            REG_LINE_COUNT:       line_n = clamp_cfg(data, MAX_LINES);
            REG_FIRST_COLOR_MODE: color_mode = data[MODE_W-1:0];
            default:              return;
        endcase
        restart_frame();
    endfunction

    function void encode_pixel(logic [PIXEL_W-1:0] p);
        logic b;
        b = (p != '0);
        pixel_codes.delete();
        if (col == 0)
        begin
            if (color_mode == MODE_COLOR_BIT)
            begin
                pack_bit(b);
                run_bit = b;
            end
            else
            begin
                run_bit = (color_mode >= MODE_FORCE_WHITE);
            end
            run_len = 1;
            tail_px = line_w;
        end
        else if (b == run_bit)
        begin
            run_len++;
        end
        else
        begin
            pack_code(run_len - 1, code_len(tail_px));
            tail_px = tail_px - run_len;
            run_bit = ~run_bit;
            run_len = 1;
        end

        if (col + 1 >= line_w)
        begin
            pack_code(run_len - 1, code_len(tail_px));
            col = 0;
            row++;
            if (row >= line_n)
            begin
                if (bit_cnt > 0)
                begin
                    emit_byte(bit_acc << (BYTE_W - bit_cnt), 1'b1);
                end
                else if (pixel_codes.size() > 0)
                begin
                    pixel_codes[pixel_codes.size() - 1].frame_end = 1'b1;
                end
                row = 0;
                bit_acc = '0;
                bit_cnt = 0;
            end
        end
        else
        begin
            col++;
        end

        if (pixel_codes.size() > 0)
        begin
            pixel_codes[pixel_codes.size() - 1].last = 1'b1;
        end
        foreach (pixel_codes[i])
        begin
            expected_codes.push_back(pixel_codes[i]);
        end
    endfunction

    function void check_code(code_item_t got);
        code_item_t want;
        codes_seen++;
        if (expected_codes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected code byte %02h frame_end %0b last %0b",
                         got.code_byte, got.frame_end, got.last);
            end
        end
        else
        begin
            want = expected_codes.pop_front();
            if (got.code_byte !== want.code_byte || got.frame_end !== want.frame_end
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("code byte %0d: expected %02h fe %0b last %0b,",
                             codes_seen, want.code_byte, want.frame_end, want.last);
                    $display("    got %02h fe %0b last %0b",
                             got.code_byte, got.frame_end, got.last);
                end
            end
        end
    endfunction

    always @(negedge clk)
    begin
        code_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_ch.valid && pixel_ch.ready) || (code_ch.valid && code_ch.ready) || write_en)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("no item moved for %0d cycles", STALL_LIMIT);
                $display("binary_line_run_length_encoder: mismatch");
                $finish;
            end
            else if (code_ch.valid && code_ch.ready)
            begin
                check_code('{code_ch.code_byte, code_ch.frame_end, code_ch.last});
            end
        end
    end

    task automatic send_pixel(logic [PIXEL_W-1:0] p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.pixel <= p;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        encode_pixel(p);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        while (expected_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
        wait_drained();
        @(negedge clk);
        write_en    <= 1'b1;
        write_index <= idx;
        write_data  <= data;
        @(posedge clk);
        apply_write(idx, data);
        cfg_writes++;
        @(negedge clk);
        write_en <= 1'b0;
    endtask

    task automatic send_image(int unsigned w, int unsigned denom, int unsigned npx);
        logic bit_v;
        bit_v = 1'b0;
        for (int unsigned i = 0; i < npx; i++)
        begin
            if (i % w == 0)
            begin
                bit_v = $urandom_range(1);
            end
            else if ($urandom_range(denom - 1) == 0)
            begin
                bit_v = ~bit_v;
            end
            // sprinkle isolated noise pixels
            if ($urandom_range(31) == 0)
            begin
                bit_v = $urandom_range(1);
            end
            send_pixel(bit_v ? 8'($urandom_range(1, 255)) : 8'h00);
        end
    endtask

    task automatic test_reset_state();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        send_pixel(8'h80);
    endtask

    task automatic test_register_limits();
        write_reg(REG_LINE_WIDTH, '0);
        write_reg(REG_LINE_COUNT, CFG_W'(CFG_MAX));
        write_reg(REG_FIRST_COLOR_MODE, CFG_W'(MODE_COLOR_BIT));
        send_pixel(8'hFF);
        send_pixel(8'h00);
        // drop the partial byte
        write_reg(REG_LINE_WIDTH, CFG_W'(CFG_MAX));
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h7F);
        // frame must carry on
        write_reg(REG_UNUSED, CFG_W'(CFG_MAX));
        send_pixel(8'h7F);
        send_pixel(8'h00);
    endtask

    task automatic test_color_modes();
        logic [MODE_W-1:0] modes [4];
        modes = '{MODE_COLOR_BIT, MODE_FORCE_BLACK, MODE_FORCE_WHITE, MODE_SPARE};
        write_reg(REG_LINE_WIDTH, CFG_W'(3));
        write_reg(REG_LINE_COUNT, CFG_W'(1));
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_FIRST_COLOR_MODE, CFG_W'(modes[m]));
            send_pixel(8'h01);
            send_pixel(8'h00);
            send_pixel(8'hFF);
        end
    endtask

    task automatic test_aligned_frame_end();
        write_reg(REG_LINE_WIDTH, CFG_W'(1));
        write_reg(REG_LINE_COUNT, CFG_W'(4));
        write_reg(REG_FIRST_COLOR_MODE, CFG_W'(MODE_COLOR_BIT));
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
    endtask

    task automatic test_full_width_line();
        write_reg(REG_LINE_COUNT, CFG_W'(1));
        write_reg(REG_FIRST_COLOR_MODE, CFG_W'($urandom_range(0, 3)));
        write_reg(REG_LINE_WIDTH, CFG_W'(MAX_WIDTH));
        // start of a widest line: long codes for the first runs
        send_image(line_w, 8, WIDE_LINE_PX);
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                             int unsigned item_goal);
        int unsigned first_px;
        int unsigned used;
        int unsigned w;
        int unsigned n;
        int unsigned r;
        int unsigned npx;
        int unsigned denom;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first_px       = pixels_sent;
        while (pixels_sent - first_px < item_goal)
        begin
            r = $urandom_range(99);
            w = (r < 70) ? $urandom_range(1, 12) :
                (r < 95) ? $urandom_range(13, 64) : $urandom_range(65, 300);
            n = (w > 64) ? 1 : $urandom_range(1, 4);
            if ($urandom_range(19) == 0)
            begin
                w = 0;
            end
            if ($urandom_range(19) == 0)
            begin
                n = 0;
            end
            write_reg(REG_LINE_WIDTH, CFG_W'(w));
            write_reg(REG_LINE_COUNT, CFG_W'(n));
            write_reg(REG_FIRST_COLOR_MODE, CFG_W'($urandom));
            if ($urandom_range(7) == 0)
            begin
                write_reg(REG_UNUSED, CFG_W'($urandom));
            end
            r = $urandom_range(2);
            denom = (r == 0) ? 2 : (r == 1) ? 4 : 16;
            npx = line_w * line_n;
            // cut some frames short
            if (npx > 1 && $urandom_range(9) == 0)
            begin
                npx = $urandom_range(1, npx - 1);
            end
            // hold the phase near its item budget
            used = pixels_sent - first_px;
            if (npx > item_goal + PHASE_SLACK - used)
            begin
                npx = item_goal + PHASE_SLACK - used;
            end
            send_image(line_w, denom, npx);
        end
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 60);
        run_phase(82, 0, 60);
        run_phase(0, 82, 60);
        run_phase(6, 6, 60);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        write_en       = 1'b0;
        write_index    = REG_LINE_WIDTH;
        write_data     = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel = '0;
        code_ch.ready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_register_limits();
        test_color_modes();
        test_aligned_frame_end();
        test_full_width_line();
        test_random_traffic();
        wait_drained();

        $display("covered %0d pixels, %0d register writes and %0d code bytes",
                 pixels_sent, cfg_writes, codes_seen);
        $display("widths 1 to %0d, all color modes, sender gaps and receiver stalls",
                 MAX_WIDTH);
        if (mismatches == 0 && expected_codes.size() == 0)
        begin
            $display("binary_line_run_length_encoder: match");
        end
        else
        begin
            $display("binary_line_run_length_encoder: mismatch");
        end
        $finish;
    end

endmodule
